/* sv/pift_pkg.sv */
package pift_pkg;

  // Field widths of the ports and registers.
  localparam int CoordW  = 21;
  localparam int AxisW   = 21;
  localparam int VecW    = 3 * CoordW;
  localparam int DistW   = 20;
  localparam int TanW    = 24;
  localparam int AspW    = 20;
  localparam int AddrW   = 6;
  localparam int DataW   = 64;

  // Internal widths of the datapath.
  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = AxisW + DiffW;
  localparam int DotW    = ProdW + 2;
  localparam int MagW    = DotW;
  localparam int DepthW  = DistW + 19;
  localparam int HbW     = DepthW + TanW;
  localparam int PpLoW   = 32 + AspW;
  localparam int PpHiW   = (HbW - 32) + AspW;
  localparam int WideW   = HbW + AspW;

  // Stages in the front (projection) and back (bounds) halves.
  localparam int FrontStages = 3;
  localparam int BackStages  = 3;
  localparam int NumStages   = FrontStages + BackStages;

  // Register map, one register every eight bytes.
  typedef enum logic [2:0] {
    RegCamPos    = 3'd0,
    RegViewDir   = 3'd1,
    RegUpAxis    = 3'd2,
    RegRightAxis = 3'd3,
    RegNear      = 3'd4,
    RegFar       = 3'd5,
    RegTan       = 3'd6,
    RegAspect    = 3'd7
  } reg_idx_e;

  localparam logic [VecW-1:0]  RstCamPos    = '0;
  localparam logic [VecW-1:0]  RstViewDir   = 63'h2000_0000_0000_0000;
  localparam logic [VecW-1:0]  RstUpAxis    = 63'h0000_0300_0000_0000;
  localparam logic [VecW-1:0]  RstRightAxis = 63'h0000_0000_0018_0000;
  localparam logic [DistW-1:0] RstNear      = 20'd26;
  localparam logic [DistW-1:0] RstFar       = 20'd25600;
  localparam logic [TanW-1:0]  RstTan       = 24'd27146;
  localparam logic [AspW-1:0]  RstAspect    = 20'd87381;

  typedef struct packed {
    logic [VecW-1:0]  cam_pos;
    logic [VecW-1:0]  view_dir;
    logic [VecW-1:0]  up_axis;
    logic [VecW-1:0]  right_axis;
    logic [DistW-1:0] near_dist;
    logic [DistW-1:0] far_dist;
    logic [TanW-1:0]  tan_half_fov;
    logic [AspW-1:0]  aspect_ratio;
  } cfg_t;

  // One signed 21-bit component of a packed x,y,z vector.
  function automatic logic signed [CoordW-1:0] lane_of(logic [VecW-1:0] v, int unsigned i);
    return signed'(v[i*CoordW +: CoordW]);
  endfunction

endpackage

/* sv/pift_cfg.sv */
module pift_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pift_pkg::AddrW-1:0]  paddr,
  input  logic [pift_pkg::DataW-1:0]  pwdata,
  output logic [pift_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output pift_pkg::cfg_t              cfg_o
);
  import pift_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[AddrW-1:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_pos      <= RstCamPos;
      cfg_q.view_dir     <= RstViewDir;
      cfg_q.up_axis      <= RstUpAxis;
      cfg_q.right_axis   <= RstRightAxis;
      cfg_q.near_dist    <= RstNear;
      cfg_q.far_dist     <= RstFar;
      cfg_q.tan_half_fov <= RstTan;
      cfg_q.aspect_ratio <= RstAspect;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        RegCamPos:    cfg_q.cam_pos      <= pwdata[VecW-1:0];
        RegViewDir:   cfg_q.view_dir     <= pwdata[VecW-1:0];
        RegUpAxis:    cfg_q.up_axis      <= pwdata[VecW-1:0];
        RegRightAxis: cfg_q.right_axis   <= pwdata[VecW-1:0];
        RegNear:      cfg_q.near_dist    <= pwdata[DistW-1:0];
        RegFar:       cfg_q.far_dist     <= pwdata[DistW-1:0];
        RegTan:       cfg_q.tan_half_fov <= pwdata[TanW-1:0];
        RegAspect:    cfg_q.aspect_ratio <= pwdata[AspW-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegCamPos:    prdata = DataW'(cfg_q.cam_pos);
      RegViewDir:   prdata = DataW'(cfg_q.view_dir);
      RegUpAxis:    prdata = DataW'(cfg_q.up_axis);
      RegRightAxis: prdata = DataW'(cfg_q.right_axis);
      RegNear:      prdata = DataW'(cfg_q.near_dist);
      RegFar:       prdata = DataW'(cfg_q.far_dist);
      RegTan:       prdata = DataW'(cfg_q.tan_half_fov);
      RegAspect:    prdata = DataW'(cfg_q.aspect_ratio);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/pift_proj.sv */
module pift_proj (
  input  logic                                clk_i,
  input  logic [pift_pkg::FrontStages-1:0]    en_i,
  input  logic signed [pift_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [pift_pkg::CoordW-1:0]  point_y_i,
  input  logic signed [pift_pkg::CoordW-1:0]  point_z_i,
  input  logic [pift_pkg::VecW-1:0]           cam_pos_i,
  input  logic [pift_pkg::VecW-1:0]           view_dir_i,
  input  logic [pift_pkg::VecW-1:0]           up_axis_i,
  input  logic [pift_pkg::VecW-1:0]           right_axis_i,
  output logic signed [pift_pkg::DotW-1:0]    depth_o,
  output logic signed [pift_pkg::DotW-1:0]    up_o,
  output logic signed [pift_pkg::DotW-1:0]    right_o
);
  import pift_pkg::*;

  logic signed [CoordW-1:0] pt   [3];
  logic [VecW-1:0]          axis [3];
  logic signed [DiffW-1:0]  diff_q [3];
  logic signed [ProdW-1:0]  prod_q [3][3];
  logic signed [DotW-1:0]   dot_q  [3];

  assign pt[0]   = point_x_i;
  assign pt[1]   = point_y_i;
  assign pt[2]   = point_z_i;
  assign axis[0] = view_dir_i;
  assign axis[1] = up_axis_i;
  assign axis[2] = right_axis_i;

  // Point relative to the camera.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int i = 0; i < 3; i++) begin
        diff_q[i] <= DiffW'(pt[i]) - DiffW'(lane_of(cam_pos_i, i));
      end
    end
  end

  // Nine component products, each one signed 21 by 22 bit multiplier.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[a][i] <= ProdW'(lane_of(axis[a], i)) * ProdW'(diff_q[i]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int a = 0; a < 3; a++) begin
        dot_q[a] <= DotW'(prod_q[a][0]) + DotW'(prod_q[a][1]) + DotW'(prod_q[a][2]);
      end
    end
  end

  assign depth_o = dot_q[0];
  assign up_o    = dot_q[1];
  assign right_o = dot_q[2];

endmodule

/* sv/pift_bound.sv */
module pift_bound (
  input  logic                              clk_i,
  input  logic [pift_pkg::BackStages-1:0]   en_i,
  input  logic signed [pift_pkg::DotW-1:0]  depth_i,
  input  logic signed [pift_pkg::DotW-1:0]  up_i,
  input  logic signed [pift_pkg::DotW-1:0]  right_i,
  input  logic [pift_pkg::DistW-1:0]        near_i,
  input  logic [pift_pkg::DistW-1:0]        far_i,
  input  logic [pift_pkg::TanW-1:0]         tan_i,
  input  logic [pift_pkg::AspW-1:0]         aspect_i,
  output logic                              inside_o
);
  import pift_pkg::*;

  logic signed [DotW-1:0] near_lim, far_lim;
  logic [MagW-1:0]        ay, ax;
  logic                   depth_ok_q, h_ok_q, inside_q;
  logic [HbW-1:0]         hbound_q;
  logic [MagW-1:0]        ay_q, ax_q, ax2_q;
  logic [PpLoW-1:0]       pp_lo_q;
  logic [PpHiW-1:0]       pp_hi_q;
  logic [WideW-1:0]       wbound, wlhs;

  assign near_lim = signed'(DotW'({near_i, 19'b0}));
  assign far_lim  = signed'(DotW'({far_i, 19'b0}));
  // The magnitude of the most negative value still fits as unsigned.
  assign ay = up_i[DotW-1]    ? MagW'(~up_i + 1'b1)    : MagW'(up_i);
  assign ax = right_i[DotW-1] ? MagW'(~right_i + 1'b1) : MagW'(right_i);

  // Depth range and the half-height bound depth * tan.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      depth_ok_q <= (depth_i >= near_lim) && (depth_i <= far_lim);
      hbound_q   <= HbW'(depth_i[DepthW-1:0]) * HbW'(tan_i);
      ay_q       <= ay;
      ax_q       <= ax;
    end
  end

  // Vertical test, and the half-width bound split into two partial products.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      h_ok_q  <= depth_ok_q && (HbW'({ay_q, 16'b0}) <= hbound_q);
      pp_lo_q <= PpLoW'(hbound_q[31:0]) * PpLoW'(aspect_i);
      pp_hi_q <= PpHiW'(hbound_q[HbW-1:32]) * PpHiW'(aspect_i);
      ax2_q   <= ax_q;
    end
  end

  assign wbound = {pp_hi_q, 32'b0} + WideW'(pp_lo_q);
  assign wlhs   = WideW'({ax2_q, 32'b0});

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      inside_q <= h_ok_q && (wlhs <= wbound);
    end
  end

  assign inside_o = inside_q;

endmodule

/* sv/point_in_frustum_test_core.sv */
// Point-in-frustum test core: an item accepted at the input has its result offered
// from the output register of the sixth stage. Throughput is one item per cycle unless
// the output stalls; the nine 21 by 22 bit products and the split half-width product
// each have a stage of their own, so nothing iterates.
// Reset (asynchronous, active low) empties the pipeline and loads the default camera:
// origin, looking along +z, near 26, far 25600, tan 27146 and aspect 87381.
module point_in_frustum_test_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pift_pkg::AddrW-1:0]         paddr,
  input  logic [pift_pkg::DataW-1:0]         pwdata,
  output logic [pift_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [pift_pkg::CoordW-1:0] point_x_i,
  input  logic signed [pift_pkg::CoordW-1:0] point_y_i,
  input  logic signed [pift_pkg::CoordW-1:0] point_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               inside_res_o
);
  import pift_pkg::*;

  // The configuration registers feed the datapath directly; the user ensures they are
  // only rewritten while the pipeline is empty, so no item sees a change mid-flight.
  cfg_t cfg;

  pift_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Each stage holds a valid bit. A stage loads when it is empty or when the
  // stage after it loads in the same cycle, so bubbles are squeezed out and
  // an item is still taken while a finished result waits at the output.
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;
  logic                 in_accept;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];
  assign in_accept  = in_valid_i && en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Front half: offset from the camera, the products and the three dot
  // products (depth, up and right projections).
  logic signed [DotW-1:0] depth, up_proj, right_proj;

  pift_proj u_proj (
    .clk_i        (clk_i),
    .en_i         (en[FrontStages-1:0]),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .cam_pos_i    (cfg.cam_pos),
    .view_dir_i   (cfg.view_dir),
    .up_axis_i    (cfg.up_axis),
    .right_axis_i (cfg.right_axis),
    .depth_o      (depth),
    .up_o         (up_proj),
    .right_o      (right_proj)
  );

  // Back half: depth range, the half-height test and the exact half-width
  // test; its last register is the output register of the block.
  pift_bound u_bound (
    .clk_i    (clk_i),
    .en_i     (en[NumStages-1:FrontStages]),
    .depth_i  (depth),
    .up_i     (up_proj),
    .right_i  (right_proj),
    .near_i   (cfg.near_dist),
    .far_i    (cfg.far_dist),
    .tan_i    (cfg.tan_half_fov),
    .aspect_i (cfg.aspect_ratio),
    .inside_o (inside_res_o)
  );

  assign out_valid_o = valid_q[NumStages-1];

  // With the output empty the whole pipeline can move, so input is never held off.
  a_accept_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !out_valid_o |-> !in_stall_o
  ) else $error("input stalled although the output stage is empty");

  // An empty pipeline that takes nothing cannot offer a result next cycle.
  a_no_phantom_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_q == '0 && !in_accept) |=> !out_valid_o
  ) else $error("result appeared from an empty pipeline");

  // A held item in the first stage must hold off the input.
  a_first_stage_backpressure: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (valid_q[0] && !en[1]) |-> in_stall_o
  ) else $error("first stage would be overwritten while it holds an item");

endmodule

/* tb/tb_point_in_frustum_test_core.sv */
module tb_point_in_frustum_test_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pift_pkg::*;

  // The run is split into phases, each streaming points under one idling pattern. Before its
  // points, each phase but the first loads a camera setting over the register port with the core idle.
  localparam int NumPhases     = 9;
  localparam int PointsPerPhase = 120;
  localparam int NumDirected   = 22;
  localparam int CycleLimit    = 200000;
  localparam int HoldCycles    = 150;
  localparam int TailCycles    = 20;
  localparam int AxisOne       = 524288;  // 1.0 in Q1.19
  localparam int CoordMax      = 1048575;
  localparam int CoordMin      = -1048576;

  logic                     clk_i;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [AddrW-1:0]         paddr = '0;
  logic [DataW-1:0]         pwdata = '0;
  logic [DataW-1:0]         prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] point_x_i = '0;
  logic signed [CoordW-1:0] point_y_i = '0;
  logic signed [CoordW-1:0] point_z_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     inside_res_o;

  // Idling pattern of the current phase, in percent of cycles.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off; the receiver clears it.
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned points_sent = 0;

  // Hand-picked points for the reset camera: the origin, both depth bounds and the
  // points just beyond them, the edges of the vertical and horizontal field of view,
  // and the extremes of the coordinate range.
  int directed_pts [NumDirected][3] = '{
    '{0, 0, 0},                '{0, 0, 26},             '{0, 0, 25},
    '{0, 0, 25600},            '{0, 0, 25601},          '{0, 10604, 25600},
    '{0, 10605, 25600},        '{0, -10604, 25600},     '{0, -10605, 25600},
    '{14138, 0, 25600},        '{14139, 0, 25600},      '{-14138, 0, 25600},
    '{-14139, 0, 25600},       '{14138, 10604, 25600},
    '{1048575, 1048575, 1048575}, '{-1048576, -1048576, -1048576},
    '{1048575, -1048576, 0},   '{-1048576, 1048575, 1048575},
    '{0, 0, 1048575},          '{0, 0, -1048576},       '{256, 256, 1024},
    '{-1, -1, -1}
  };

  point_in_frustum_test_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .inside_res_o (inside_res_o)
  );

  // Signed 21-bit component i of a packed x,y,z vector, sign-extended to 64 bits.
  function automatic longint coord_of(logic [VecW-1:0] v, int i);
    logic [CoordW-1:0] f;
    f = v[i*CoordW +: CoordW];
    return {{(64-CoordW){f[CoordW-1]}}, f};
  endfunction

  // Keeps its own copy of the camera registers, works out the inside flag of every
  // accepted point, and compares the results in order as they leave the core.
  class frustum_scoreboard;
    cfg_t        cam;
    bit          inside_expected_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      cam.cam_pos      = RstCamPos;
      cam.view_dir     = RstViewDir;
      cam.up_axis      = RstUpAxis;
      cam.right_axis   = RstRightAxis;
      cam.near_dist    = RstNear;
      cam.far_dist     = RstFar;
      cam.tan_half_fov = RstTan;
      cam.aspect_ratio = RstAspect;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [DataW-1:0] v);
      case (idx)
        RegCamPos:    cam.cam_pos      = v[VecW-1:0];
        RegViewDir:   cam.view_dir     = v[VecW-1:0];
        RegUpAxis:    cam.up_axis      = v[VecW-1:0];
        RegRightAxis: cam.right_axis   = v[VecW-1:0];
        RegNear:      cam.near_dist    = v[DistW-1:0];
        RegFar:       cam.far_dist     = v[DistW-1:0];
        RegTan:       cam.tan_half_fov = v[TanW-1:0];
        RegAspect:    cam.aspect_ratio = v[AspW-1:0];
        default: ;
      endcase
    endfunction

    // Exact integer test: depth within near..far, then the two field-of-view bounds
    // compared at 128 bits so that nothing can wrap.
    function bit point_is_inside(logic [VecW-1:0] pt);
      longint        diff[3];
      longint        dz, dy, dx, near_b, far_b;
      logic [127:0]  depth_w, tan_w, asp_w, hbound, half_w, mag_y, mag_x;
      dz = 0;
      dy = 0;
      dx = 0;
      for (int i = 0; i < 3; i++) begin
        diff[i] = coord_of(pt, i) - coord_of(cam.cam_pos, i);
        dz += coord_of(cam.view_dir, i) * diff[i];
        dy += coord_of(cam.up_axis, i) * diff[i];
        dx += coord_of(cam.right_axis, i) * diff[i];
      end
      near_b = {25'b0, cam.near_dist, 19'b0};
      far_b  = {25'b0, cam.far_dist, 19'b0};
      if (dz < near_b || dz > far_b) return 1'b0;
      depth_w = {64'b0, dz};
      tan_w   = {104'b0, cam.tan_half_fov};
      hbound  = depth_w * tan_w;
      mag_y   = {64'b0, (dy < 0) ? -dy : dy};
      if ((mag_y << 16) > hbound) return 1'b0;
      asp_w  = {108'b0, cam.aspect_ratio};
      half_w = hbound * asp_w;
      mag_x  = {64'b0, (dx < 0) ? -dx : dx};
      return (mag_x << 32) <= half_w;
    endfunction

    function void note_point(logic [CoordW-1:0] px, logic [CoordW-1:0] py,
                             logic [CoordW-1:0] pz);
      inside_expected_q.push_back(point_is_inside({pz, py, px}));
    endfunction

    function void check_result(logic got);
      bit want;
      if (inside_expected_q.size() == 0) begin
        $display("%0t: inside_res %b arrived with no point waiting, expected nothing",
                 $realtime, got);
        mismatches++;
        return;
      end
      want = inside_expected_q.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: inside_res mismatch, expected %b, actual %b", $realtime, want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return inside_expected_q.size();
    endfunction
  endclass

  frustum_scoreboard frustum_sb = new();

  // 2 ns clock.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog. A correct run ends long before this limit, even with every result waiting
  // out the heaviest back-pressure and the long hold-off.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Both monitors sample the values that were present at the rising edge, so the order
  // in which processes wake up within that step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      frustum_sb.note_point(point_x_i, point_y_i, point_z_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      frustum_sb.check_result(inside_res_o);
  end

  // Receiver. It stalls at random at the rate of the current phase and, when asked,
  // holds off for a long stretch that it counts itself, so that the pipeline fills up
  // and the core has to stall its input.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic [DataW-1:0] pack3(int x, int y, int z);
    logic [DataW-1:0] v;
    v = '0;
    v[0*CoordW +: CoordW] = x[CoordW-1:0];
    v[1*CoordW +: CoordW] = y[CoordW-1:0];
    v[2*CoordW +: CoordW] = z[CoordW-1:0];
    return v;
  endfunction

  function automatic real rand_between(real lo, real hi);
    return lo + (hi - lo) * ($urandom / 4294967296.0);
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(5))
      0: return CoordMax;
      1: return CoordMin;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return $urandom_range(511) - 256;
    endcase
  endfunction

  // A register write: a setup phase, then the access phase. The bits above the
  // register's width are filled with junk, which the core must ignore.
  task automatic apb_write(reg_idx_e idx, logic [DataW-1:0] value, int unsigned width);
    logic [DataW-1:0] keep, data;
    keep = (width >= DataW) ? '1 : ((64'd1 << width) - 64'd1);
    data = (value & keep) | ({$urandom, $urandom} & ~keep);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frustum_sb.write_reg(idx, data);
  endtask

  task automatic load_camera(logic [DataW-1:0] pos, logic [DataW-1:0] view,
                             logic [DataW-1:0] up, logic [DataW-1:0] right,
                             logic [DataW-1:0] near_d, logic [DataW-1:0] far_d,
                             logic [DataW-1:0] tan_v, logic [DataW-1:0] asp_v);
    apb_write(RegCamPos,    pos,    VecW);
    apb_write(RegViewDir,   view,   VecW);
    apb_write(RegUpAxis,    up,     VecW);
    apb_write(RegRightAxis, right,  VecW);
    apb_write(RegNear,      near_d, DistW);
    apb_write(RegFar,       far_d,  DistW);
    apb_write(RegTan,       tan_v,  TanW);
    apb_write(RegAspect,    asp_v,  AspW);
  endtask

  // Camera settings, one per phase. Phase 0 keeps the reset values.
  task automatic set_camera(int phase);
    int s6, s8;
    s6 = 314573;  // 0.6 in Q1.19
    s8 = 419430;  // 0.8 in Q1.19
    case (phase)
      // Camera moved off the origin, looking along +x; widest possible view and
      // the full depth range from zero.
      1: load_camera(pack3(25600, -12800, 6400), pack3(AxisOne, 0, 0),
                     pack3(0, 0, AxisOne), pack3(0, -AxisOne, 0),
                     64'd0, 64'hF_FFFF, 64'hFF_FFFF, 64'hF_FFFF);
      // Near plane beyond the far plane: nothing can be inside.
      2: load_camera(pack3(-300, 700, 50), pack3(0, 0, AxisOne),
                     pack3(0, AxisOne, 0), pack3(AxisOne, 0, 0),
                     64'd5000, 64'd4000, 64'd32768, 64'd98304);
      // Zero field of view: only points on the view line itself pass.
      3: load_camera(pack3(128, -64, 32), pack3(s6, 0, s8),
                     pack3(0, AxisOne, 0), pack3(s8, 0, -s6),
                     64'd256, 64'd200000, 64'd0, 64'd0);
      // An ordinary rotated camera.
      4: load_camera(pack3($urandom_range(20000) - 10000, $urandom_range(20000) - 10000,
                           $urandom_range(20000) - 10000),
                     pack3(0, s6, s8), pack3(0, s8, -s6), pack3(AxisOne, 0, 0),
                     64'd256, 64'd128000, 64'd32768, 64'd98304);
      // Everything random, axes of any length and direction.
      5: load_camera({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
      // Every register at all ones.
      6: load_camera('1, '1, '1, '1, '1, '1, '1, '1);
      // Every register at zero: depth zero passes both bounds, so all points are inside.
      7: load_camera('0, '0, '0, '0, '0, '0, '0, '0);
      // The reset camera again, written explicitly, from a random position.
      default: load_camera(pack3($urandom, $urandom, $urandom), RstViewDir, RstUpAxis,
                           RstRightAxis, RstNear, RstFar, RstTan, RstAspect);
    endcase
  endtask

  // Mostly points placed in the frame of the current camera, near the depth bounds and
  // the edges of the view, so that every comparison is exercised from both sides; the
  // rest are fully random points and points at the ends of the coordinate range.
  task automatic pick_point(output int px, output int py, output int pz);
    int          kind, pc[3];
    real         nr, fr, lo, hi, span, t, u, r, hh, hw, c;
    kind = $urandom_range(99);
    if (kind < 15) begin
      px = $urandom;
      py = $urandom;
      pz = $urandom;
      return;
    end
    if (kind < 25) begin
      px = extreme_coord();
      py = extreme_coord();
      pz = extreme_coord();
      return;
    end
    nr = frustum_sb.cam.near_dist;
    fr = frustum_sb.cam.far_dist;
    lo = (nr < fr) ? nr : fr;
    hi = (nr < fr) ? fr : nr;
    span = hi - lo;
    case ($urandom_range(9))
      0: t = nr;
      1: t = fr;
      2: t = nr - 1.0;
      3: t = fr + 1.0;
      default: t = rand_between(lo - 0.05 * span - 2.0, hi + 0.05 * span + 2.0);
    endcase
    hh = t * frustum_sb.cam.tan_half_fov / 65536.0;
    hw = hh * frustum_sb.cam.aspect_ratio / 65536.0;
    u = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? hh : -hh)
                                 : rand_between(-1.1, 1.1) * hh;
    r = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? hw : -hw)
                                 : rand_between(-1.1, 1.1) * hw;
    for (int i = 0; i < 3; i++) begin
      c = coord_of(frustum_sb.cam.cam_pos, i)
          + (t * coord_of(frustum_sb.cam.view_dir, i)
             + u * coord_of(frustum_sb.cam.up_axis, i)
             + r * coord_of(frustum_sb.cam.right_axis, i)) / 524288.0;
      c = c + $urandom_range(2) - 1.0;
      if (c > CoordMax) c = CoordMax;
      if (c < CoordMin) c = CoordMin;
      pc[i] = $rtoi(c);
    end
    px = pc[0];
    py = pc[1];
    pz = pc[2];
  endtask

  // Offers one point and holds it until the core takes it. Valid is only lowered when
  // an idle gap is actually wanted, so it never drops and rises within one step.
  task automatic send_point(int px, int py, int pz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    point_x_i  <= px[CoordW-1:0];
    point_y_i  <= py[CoordW-1:0];
    point_z_i  <= pz[CoordW-1:0];
    do @(posedge clk_i); while (in_stall_o);
    points_sent++;
  endtask

  // Stops offering and waits until every outstanding result has come back. It always waits
  // for a clock edge, so valid is never raised again in the step where it was lowered.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frustum_sb.pending() != 0);
  endtask

  // Main stimulus.
  initial begin
    int px, py, pz;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points against the reset camera, free flow on both sides.
    for (int i = 0; i < NumDirected; i++)
      send_point(directed_pts[i][0], directed_pts[i][1], directed_pts[i][2]);

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        drain_results();
        set_camera(phase);
      end
      // Idling pattern: free flow, sparse input, heavy back-pressure, light on both.
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      for (int n = 0; n < PointsPerPhase; n++) begin
        // In the rotated-camera phase the receiver holds off for a long stretch while
        // points keep coming, and later the sender waits for the pipeline to empty.
        if (phase == 4 && n == 40) hold_req = 1'b1;
        if (phase == 4 && n == 80) drain_results();
        pick_point(px, py, pz);
        send_point(px, py, pz);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    $display("Sent %0d points (%0d directed) over %0d camera settings, %0d results checked.",
             points_sent, NumDirected, NumPhases, frustum_sb.checked);
    $display("Idling covered free flow, sparse input, heavy and long output hold-off, full drain.");
    if (frustum_sb.mismatches == 0 && frustum_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results still expected", frustum_sb.mismatches,
               frustum_sb.pending());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
